@@ rtl/imdu_pkg.sv @@
// shared constants and types for the integer multiply/divide unit
`default_nettype none

package imdu_pkg;

  // data width of the operands and the result
  localparam int unsigned DataWidth = 32;
  // width of the bit counter that steps through one word
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  // action codes
  localparam logic [2:0] ACT_MUL_S = 3'd0;
  localparam logic [2:0] ACT_MUL_U = 3'd1;
  localparam logic [2:0] ACT_DIV_S = 3'd2;
  localparam logic [2:0] ACT_DIV_U = 3'd3;
  localparam logic [2:0] ACT_REM_S = 3'd4;
  localparam logic [2:0] ACT_REM_U = 3'd5;

  // which word the final step reads out
  typedef enum logic [1:0] {
    KIND_MUL,
    KIND_DIV,
    KIND_REM
  } kind_e;

endpackage

`default_nettype wire

@@ rtl/integer_mul_div_unit.sv @@
// radix-2 iterative integer multiply/divide unit, one result bit per cycle
// a multiply or divide request runs one loop step per operand bit, then a final step
//   fixes signs and loads the output register, waiting while it is full and stalled
// divide by zero and unused action codes skip the loop and go straight to the final step
// a new request is taken only in idle, after the previous result is loaded; the result register lets the
//   next request start while the previous result waits to be taken
// reset: rst_ni asynchronous, active low; clears state and the output valid
`default_nettype none

module integer_mul_div_unit import imdu_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           action_i,
  input  wire logic [DataWidth-1:0] operand_a_i,
  input  wire logic [DataWidth-1:0] operand_b_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DataWidth-1:0]      result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } state_e;

  state_e                 state_q;
  logic [CntWidth-1:0]    cnt_q;
  logic                   out_valid_q;
  logic [DataWidth-1:0]   result_q;

  // datapath: accumulator / partial remainder, shift word, operand word
  logic [DataWidth-1:0]   acc_q, acc_d;
  logic [DataWidth-1:0]   sh_q, sh_d;
  logic [DataWidth-1:0]   op_q, op_d;
  kind_e                  kind_q, kind_d;
  logic                   neg_q, neg_d;
  logic                   skip_d;

  logic                   in_accept;
  logic                   fin_load;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // request decode: operand signs, magnitudes and the zero-divisor flag
  logic                 sign_a, sign_b, b_zero;
  logic [DataWidth-1:0] mag_a, mag_b;

  always_comb begin
    sign_a = operand_a_i[DataWidth-1];
    sign_b = operand_b_i[DataWidth-1];
    b_zero = (operand_b_i == '0);
    mag_a  = sign_a ? (DataWidth'(0) - operand_a_i) : operand_a_i;
    mag_b  = sign_b ? (DataWidth'(0) - operand_b_i) : operand_b_i;
  end

  // request load in idle, then one loop step: shift/add for multiply, restoring subtract for divide
  logic [DataWidth:0] rem_sh, diff;
  logic               ge;

  always_comb begin
    rem_sh = {acc_q, sh_q[DataWidth-1]};
    diff   = rem_sh - {1'b0, op_q};
    ge     = !diff[DataWidth];
    acc_d  = acc_q;
    sh_d   = sh_q;
    op_d   = op_q;
    kind_d = kind_q;
    neg_d  = neg_q;
    skip_d = 1'b0;
    if (state_q == ST_IDLE) begin
      acc_d = '0;
      sh_d  = operand_a_i;
      op_d  = operand_b_i;
      neg_d = 1'b0;
      case (action_i)
        ACT_MUL_S, ACT_MUL_U: begin
          kind_d = KIND_MUL;
          sh_d   = operand_b_i;
          op_d   = operand_a_i;
        end
        ACT_DIV_S: begin
          kind_d = KIND_DIV;
          sh_d   = mag_a;
          op_d   = mag_b;
          neg_d  = sign_a ^ sign_b;
        end
        ACT_DIV_U: begin
          kind_d = KIND_DIV;
        end
        ACT_REM_S: begin
          kind_d = KIND_REM;
          sh_d   = mag_a;
          op_d   = mag_b;
          neg_d  = sign_a;
        end
        ACT_REM_U: begin
          kind_d = KIND_REM;
        end
        default: begin
          // unused codes give zero
          kind_d = KIND_MUL;
          skip_d = 1'b1;
        end
      endcase
      // divide by zero: quotient 0, remainder is the raw dividend
      if ((kind_d != KIND_MUL) && b_zero) begin
        acc_d  = operand_a_i;
        sh_d   = '0;
        neg_d  = 1'b0;
        skip_d = 1'b1;
      end
    end else if (state_q == ST_CALC) begin
      if (kind_q == KIND_MUL) begin
        acc_d = acc_q + (sh_q[0] ? op_q : '0);
        sh_d  = sh_q >> 1;
        op_d  = op_q << 1;
      end else begin
        acc_d = ge ? diff[DataWidth-1:0] : rem_sh[DataWidth-1:0];
        sh_d  = {sh_q[DataWidth-2:0], ge};
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept || (state_q == ST_CALC)) begin
      acc_q  <= acc_d;
      sh_q   <= sh_d;
      op_q   <= op_d;
      kind_q <= kind_d;
      neg_q  <= neg_d;
    end
  end

  // final word select with sign fix
  logic [DataWidth-1:0] fin_word;

  always_comb begin
    case (kind_q)
      KIND_MUL: fin_word = acc_q;
      KIND_DIV: fin_word = neg_q ? (DataWidth'(0) - sh_q) : sh_q;
      KIND_REM: fin_word = neg_q ? (DataWidth'(0) - acc_q) : acc_q;
      default:  fin_word = acc_q;
    endcase
  end

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      // output register empties when its result is taken and nothing new lands
      if (out_valid_q && !out_stall_i && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            cnt_q   <= CntWidth'(DataWidth - 1);
            state_q <= skip_d ? ST_FIN : ST_CALC;
          end
        end
        ST_CALC: begin
          cnt_q <= cnt_q - CntWidth'(1);
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            result_q    <= fin_word;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // loop ends after the last bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && cnt_q == '0) |=> (state_q == ST_FIN))
    else $error("loop did not end on the last bit");

  // a request keeps the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("unit idle right after a request");

  // finished result lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> (out_valid_o && state_q == ST_IDLE))
    else $error("finished result not presented");

  // engine holds while the output register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_o && out_stall_i) |=>
      (state_q == ST_FIN && out_valid_o && $stable(result_o)))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ dv/integer_mul_div_unit_tb.sv @@
// self-checking testbench for the integer multiply/divide unit
`default_nettype none

module testbench import imdu_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // action codes the unit does not define, they must return zero
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int unsigned RandomRequests = 930;
  localparam int unsigned CalmFirst      = 300;
  localparam int unsigned CalmLast       = 450;
  localparam int unsigned HoldAt         = 700;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned DrainCycles    = 40;
  localparam realtime     RunLimit       = 5ms;

  typedef logic [DataWidth-1:0] word_t;

  // expected words in request order, plus the checking of each result
  class mul_div_scoreboard;
    word_t       expected_words[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned by_action[8];
    int unsigned zero_divisors;

    // low product word, quotient or remainder as the unit should return it
    function word_t muldiv_result(logic [2:0] act, word_t a, word_t b);
      word_t mag_a;
      word_t mag_b;
      word_t r;
      mag_a = a[DataWidth-1] ? -a : a;
      mag_b = b[DataWidth-1] ? -b : b;
      r     = '0;
      case (act)
        ACT_MUL_S, ACT_MUL_U: begin
          r = a * b;
        end
        ACT_DIV_S: begin
          if (b != '0) begin
            r = mag_a / mag_b;
            if (a[DataWidth-1] != b[DataWidth-1]) r = -r;
          end
        end
        ACT_DIV_U: begin
          if (b != '0) r = a / b;
        end
        ACT_REM_S: begin
          if (b == '0) begin
            r = a;
          end else begin
            r = mag_a % mag_b;
            // remainder follows the dividend's sign
            if (a[DataWidth-1]) r = -r;
          end
        end
        ACT_REM_U: begin
          r = (b == '0) ? a : a % b;
        end
        default: begin
          r = '0;
        end
      endcase
      return r;
    endfunction

    function void note_request(logic [2:0] act, word_t a, word_t b);
      expected_words.push_back(muldiv_result(act, a, b));
      by_action[act]++;
      if (b == '0 && act inside {ACT_DIV_S, ACT_DIV_U, ACT_REM_S, ACT_REM_U})
        zero_divisors++;
    endfunction

    function void check_result(word_t got);
      word_t want;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %h", got);
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch #%0d: expected %h, got %h", checked, want, got);
      end
    endfunction
  endclass

  // known values on every input from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = ACT_MUL_S;
  word_t       operand_a_i = '0;
  word_t       operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  word_t       result_o;

  mul_div_scoreboard board = new();

  int unsigned sent;
  bit          calm_stretch;
  bit          hold_request;
  bit          hold_done;
  int unsigned hold_left;

  integer_mul_div_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

  // 12 ns clock
  always begin
    #6ns clk_i = 1'b1;
    #6ns clk_i = 1'b0;
  end

  // offer one request, with random idle cycles ahead of it, until it is taken
  task automatic send_request(input logic [2:0] act, input word_t a, input word_t b);
    while (!calm_stretch && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(act, a, b);
    sent++;
    calm_stretch <= (sent >= CalmFirst && sent < CalmLast);
    if (sent == HoldAt) hold_request <= 1'b1;
  endtask

  // operand mix: full random, small magnitudes, boundary values, shifted words, forced top bit
  function automatic word_t pick_operand();
    word_t v;
    v = $urandom();
    case ($urandom_range(9))
      5: v = $urandom_range(15);
      6: v = -word_t'($urandom_range(15, 1));
      7: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      8: v = v >> $urandom_range(31);
      9: v[DataWidth-1] = 1'b1;
      default: ;
    endcase
    return v;
  endfunction

  // result side: check each taken result, stall at random, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(result_o);
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_request && !hold_done) begin
        hold_done   <= 1'b1;
        hold_left   <= HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm_stretch && ($urandom_range(99) < 35);
      end
    end
  end

  // main sequence
  initial begin
    int unsigned  r;
    logic [2:0]   act;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: operand extremes, every action, the special cases
    send_request(ACT_MUL_S, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_MUL_S, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ACT_MUL_S, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(ACT_MUL_S, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_MUL_U, 32'hFFFF_FFFF, 32'h0000_0002);
    send_request(ACT_MUL_U, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_MUL_U, 32'h1234_5678, 32'h9ABC_DEF0);
    // most negative over minus one, signed and negative operands, and a zero divisor
    send_request(ACT_DIV_S, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ACT_DIV_S, 32'hFFFF_FFF9, 32'h0000_0002);
    send_request(ACT_DIV_S, 32'h0000_0007, 32'hFFFF_FFFE);
    send_request(ACT_DIV_S, 32'h0000_1234, 32'h0000_0000);
    // unsigned operands with the top bit set, and a zero divisor
    send_request(ACT_DIV_U, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(ACT_DIV_U, 32'h8000_0000, 32'h0000_0003);
    send_request(ACT_DIV_U, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_DIV_U, 32'h0000_0005, 32'h0000_0000);
    send_request(ACT_REM_S, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ACT_REM_S, 32'hFFFF_FFF9, 32'h0000_0002);
    send_request(ACT_REM_S, 32'h0000_0007, 32'hFFFF_FFFE);
    send_request(ACT_REM_S, 32'h8000_0000, 32'h0000_0000);
    send_request(ACT_REM_U, 32'hFFFF_FFFF, 32'h0000_000A);
    send_request(ACT_REM_U, 32'h8000_0001, 32'h8000_0000);
    send_request(ACT_REM_U, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_SPARE_7, 32'h0000_0001, 32'h0000_0001);

    // random requests, mostly defined actions
    repeat (RandomRequests) begin
      r   = $urandom_range(99);
      act = (r < 95) ? 3'(r % 6) : ((r & 1) ? ACT_SPARE_7 : ACT_SPARE_6);
      send_request(act, pick_operand(), pick_operand());
    end
    in_valid_i <= 1'b0;

    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests: %0d mul, %0d div, %0d rem, %0d spare codes, %0d zero divisors",
             sent, board.by_action[ACT_MUL_S] + board.by_action[ACT_MUL_U],
             board.by_action[ACT_DIV_S] + board.by_action[ACT_DIV_U],
             board.by_action[ACT_REM_S] + board.by_action[ACT_REM_U],
             board.by_action[ACT_SPARE_6] + board.by_action[ACT_SPARE_7],
             board.zero_divisors);
    $display("%0d results checked, %0d failures", board.checked, board.failures);
    if (board.failures == 0 && board.expected_words.size() == 0) begin
      $display("[integer_mul_div_unit] OK");
    end else begin
      $display("[integer_mul_div_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RunLimit;
    $display("[integer_mul_div_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/imdu_pkg.sv
rtl/integer_mul_div_unit.sv
dv/integer_mul_div_unit_tb.sv
